[design/b64enc_pkg.sv]
// Shared types, constants and the alphabet mapping of the Base64 stream encoder.
package b64enc_pkg;

  localparam int unsigned LINE_W      = 10;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CHAR_W      = 7;
  localparam int unsigned SLOTS       = 4;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [CHAR_W-1:0] PAD_CHAR     = 7'h3d;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 7'h0a;

  // Leftover bit count, coded
  typedef enum logic [1:0] {
    LEFT_NONE = 2'd0,
    LEFT_TWO  = 2'd1,
    LEFT_FOUR = 2'd2
  } left_e;

  // One queue entry: the characters that a single input byte produces
  typedef struct packed {
    logic [SLOTS-1:0][CHAR_W-1:0] chars;
    logic [2:0]                   count;  // 1 to 4 valid slots, from slot 0
    logic                         eom;
  } entry_t;

  function automatic logic [CHAR_W-1:0] sextet_to_char(input logic [5:0] v);
    logic [CHAR_W-1:0] w;
    logic [CHAR_W-1:0] c;
    w = {1'b0, v};
    if (v < 6'd26) begin
      c = w + 7'd65;
    end else if (v < 6'd52) begin
      c = w + 7'd71;   // 'a' - 26
    end else if (v < 6'd62) begin
      c = w - 7'd4;    // '0' - 52
    end else if (v == 6'd62) begin
      c = 7'h2b;
    end else begin
      c = 7'h2f;
    end
    return c;
  endfunction

endpackage

[design/b64enc_front.sv]
// Front end: packs bytes into sextets, flushes and pads at message end, builds queue entries.
module b64enc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         in_byte_i,
  input  logic               in_eom_i,
  output logic               push_o,
  output b64enc_pkg::entry_t push_entry_o,
  input  logic               full_i
);
  import b64enc_pkg::*;

  left_e       left_cnt_q, left_cnt_d;
  logic [3:0]  left_bits_q, left_bits_d;
  logic [1:0]  mod4_q, mod4_d;

  logic        accept;
  logic [5:0]  c0, c1, flush;
  logic [2:0]  n_data, n_chars, n_pad;
  logic [1:0]  mod_after;
  logic        has_flush;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;

  always_comb begin
    c0          = in_byte_i[7:2];
    c1          = in_byte_i[5:0];
    left_bits_d = {2'b00, in_byte_i[1:0]};
    left_cnt_d  = LEFT_TWO;
    n_data      = 3'd1;
    unique case (left_cnt_q)
      LEFT_NONE: begin
        c0          = in_byte_i[7:2];
        left_bits_d = {2'b00, in_byte_i[1:0]};
        left_cnt_d  = LEFT_TWO;
      end
      LEFT_TWO: begin
        c0          = {left_bits_q[1:0], in_byte_i[7:4]};
        left_bits_d = in_byte_i[3:0];
        left_cnt_d  = LEFT_FOUR;
      end
      LEFT_FOUR: begin
        c0          = {left_bits_q, in_byte_i[7:6]};
        left_bits_d = 4'd0;
        left_cnt_d  = LEFT_NONE;
        n_data      = 3'd2;
      end
      default: begin
        c0          = in_byte_i[7:2];
        left_bits_d = {2'b00, in_byte_i[1:0]};
        left_cnt_d  = LEFT_TWO;
      end
    endcase

    // zero-filled trailing sextet
    flush     = (left_cnt_d == LEFT_FOUR) ? {left_bits_d, 2'b00} : {left_bits_d[1:0], 4'b0000};
    has_flush = in_eom_i && (left_cnt_d != LEFT_NONE);
    mod_after = mod4_q + n_data[1:0] + {1'b0, has_flush};
    n_pad     = in_eom_i ? {1'b0, 2'd0 - mod_after} : 3'd0;
    n_chars   = n_data + {2'b00, has_flush} + n_pad;

    push_entry_o.chars[0] = sextet_to_char(c0);
    push_entry_o.chars[1] = (n_data == 3'd2) ? sextet_to_char(c1)
                          : (has_flush ? sextet_to_char(flush) : PAD_CHAR);
    push_entry_o.chars[2] = PAD_CHAR;
    push_entry_o.chars[3] = PAD_CHAR;
    push_entry_o.count    = n_chars;
    push_entry_o.eom      = in_eom_i;

    mod4_d = in_eom_i ? 2'd0 : mod_after;
    if (in_eom_i) begin
      left_cnt_d  = LEFT_NONE;
      left_bits_d = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_cnt_q  <= LEFT_NONE;
      left_bits_q <= 4'd0;
      mod4_q      <= 2'd0;
    end else if (accept) begin
      left_cnt_q  <= left_cnt_d;
      left_bits_q <= left_bits_d;
      mod4_q      <= mod4_d;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (push_entry_o.count != 3'd0 && push_entry_o.count <= 3'd4))
    else $error("entry count out of range");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_eom_i) |=> (left_cnt_q == LEFT_NONE && mod4_q == 2'd0))
    else $error("state not cleared after message end");

  a_unused_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (left_cnt_q == LEFT_NONE) |-> (left_bits_q == 4'd0))
    else $error("stale leftover bits");

endmodule

[design/b64enc_fifo.sv]
// Small flop-based queue between the front and back ends.
module b64enc_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o,
  output logic             full_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(Depth));
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count past depth");

endmodule

[design/b64enc_back.sv]
// Back end: emits head characters one per cycle unless stalled, inserting newlines.
module b64enc_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [b64enc_pkg::LINE_W-1:0] line_length_i,
  input  b64enc_pkg::entry_t            head_i,
  input  logic                          empty_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [b64enc_pkg::CHAR_W-1:0] out_char_o,
  output logic                          out_last_o
);
  import b64enc_pkg::*;

  logic [1:0]        pos_q, pos_d;
  logic [LINE_W-1:0] col_q, col_d;
  logic              valid_q, valid_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic              last_q, last_d;

  logic load, need_nl, final_slot;

  assign load       = (!valid_q || out_ready_i) && !empty_i;
  assign need_nl    = (line_length_i != '0) && (col_q >= line_length_i);
  assign final_slot = ({1'b0, pos_q} == head_i.count - 3'd1);

  always_comb begin
    pos_d   = pos_q;
    col_d   = col_q;
    char_d  = char_q;
    last_d  = last_q;
    valid_d = valid_q && !out_ready_i;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = 1'b1;
      if (need_nl) begin
        char_d = NEWLINE_CHAR;
        last_d = 1'b0;
        col_d  = '0;
      end else begin
        char_d = head_i.chars[pos_q];
        last_d = head_i.eom && final_slot;
        col_d  = last_d ? '0 : col_q + 1'b1;
        if (final_slot) begin
          pos_d = 2'd0;
          pop_o = 1'b1;
        end else begin
          pos_d = pos_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= 2'd0;
      col_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      col_q   <= col_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;

  a_last_not_nl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && last_q) |-> (char_q != NEWLINE_CHAR))
    else $error("newline flagged as last character");

  a_pos_in_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> ({1'b0, pos_q} < head_i.count))
    else $error("slot index past entry count");

  a_last_resets_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && last_d) |=> (col_q == '0 && pos_q == 2'd0))
    else $error("column not cleared after message end");

endmodule

[design/base64_stream_encoder_unit.sv]
// Top level of the Base64 stream encoder with optional line wrapping.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata[7:0] = data_byte, tlast = end_of_message
//  m_axis    out        tdata[6:0] = out_char (tdata[7] = 0), tlast = last_char
//  cfg       in         cfg_wdata_i[9:0] = line_length, written when cfg_we_i is high
//
// Output runs at one character per cycle when not stalled; a byte gives 1 to 4
// characters plus any newlines, so the single character register on m_axis
// bounds the sustained input. The front end takes a byte every cycle while the
// entry queue has room; output stalls back up only through the queue.
// Reset is asynchronous and takes effect at once; there is no clearing pass.
module base64_stream_encoder_unit #(
  parameter int unsigned QueueDepth = b64enc_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [9:0] cfg_wdata_i,   // line_length
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] data_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [6:0] out_char, [7] zero
  output logic       m_axis_tlast
);
  import b64enc_pkg::*;

  logic [LINE_W-1:0] line_length_q;
  logic              push, pop, empty, full;
  entry_t            push_entry, head;
  logic [CHAR_W-1:0] out_char;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_length_q <= '0;
    end else if (cfg_we_i) begin
      line_length_q <= cfg_wdata_i;
    end
  end

  b64enc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .in_eom_i     (s_axis_tlast),
    .push_o       (push),
    .push_entry_o (push_entry),
    .full_i       (full)
  );

  b64enc_fifo #(
    .Width ($bits(entry_t)),
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .pop_i   (pop),
    .rdata_o (head),
    .empty_o (empty),
    .full_o  (full)
  );

  b64enc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .line_length_i (line_length_q),
    .head_i        (head),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_char_o    (out_char),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_char};

endmodule

[bench/base64_stream_encoder_unit_test.sv]
// Self-checking testbench for the Base64 stream encoder with line wrapping.
`timescale 1ns / 1ps

module base64_stream_encoder_unit_test;
  import b64enc_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned SettleCycles = 20;
  localparam logic [9:0] LineOff = 10'd0;
  localparam logic [9:0] LineMin = 10'd1;
  localparam logic [9:0] LineMax = 10'd1023;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } enc_char_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [9:0] cfg_wdata_i = '0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;   // [7:0] data_byte
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;        // [6:0] out_char, [7] zero
  logic       m_axis_tlast;

  base64_stream_encoder_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // Encoder state mirror
  string       b64_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  logic [9:0]  line_len = '0;
  logic [3:0]  enc_left_bits = '0;
  int          enc_left_cnt = 0;
  logic [9:0]  enc_column = '0;
  logic [1:0]  enc_mod4 = '0;
  enc_char_t   pending_chars[$];

  int          fail_count = 0;
  int unsigned cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_req = 1'b0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("base64_stream_encoder_unit_test: FAIL");
      $finish;
    end
  end

  // Queue one character, wrapping first if the line is already full
  function automatic void emit_char(logic [CHAR_W-1:0] ch);
    if (line_len != 0 && enc_column >= line_len) begin
      pending_chars.push_back({NEWLINE_CHAR, 1'b0});
      enc_column = '0;
    end
    pending_chars.push_back({ch, 1'b0});
    enc_column = enc_column + 10'd1;
    enc_mod4 = enc_mod4 + 2'd1;
  endfunction

  function automatic logic [CHAR_W-1:0] sextet_char(logic [5:0] idx);
    return CHAR_W'(b64_alphabet[idx]);
  endfunction

  function automatic void encode_byte(logic [7:0] b, logic eom);
    logic [11:0] acc;
    int          nbits;
    logic [5:0]  idx;
    enc_char_t   tail;
    acc = {enc_left_bits, b};
    nbits = enc_left_cnt + 8;
    while (nbits >= 6) begin
      nbits -= 6;
      idx = 6'(acc >> nbits);
      emit_char(sextet_char(idx));
    end
    enc_left_bits = 4'(acc & ((12'd1 << nbits) - 12'd1));
    enc_left_cnt = nbits;
    if (eom) begin
      if (enc_left_cnt > 0) begin
        idx = 6'({2'b00, enc_left_bits} << (6 - enc_left_cnt));
        emit_char(sextet_char(idx));
      end
      while (enc_mod4 != 0) emit_char(PAD_CHAR);
      tail = pending_chars.pop_back();
      tail.last = 1'b1;
      pending_chars.push_back(tail);
      enc_left_bits = '0;
      enc_left_cnt = 0;
      enc_column = '0;
      enc_mod4 = '0;
    end
  endfunction

  // Receive side: check each transfer, then pick tready for the next cycle
  always @(posedge clk_i) begin
    int        hold_left;
    enc_char_t exp_char;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected character: out_char actual %0h", m_axis_tdata[6:0]);
        fail_count++;
      end else begin
        exp_char = pending_chars.pop_front();
        if (m_axis_tdata[6:0] !== exp_char.ch) begin
          $error("out_char mismatch: expected %0h actual %0h", exp_char.ch, m_axis_tdata[6:0]);
          fail_count++;
        end
        if (m_axis_tlast !== exp_char.last) begin
          $error("last_char mismatch: expected %0b actual %0b", exp_char.last, m_axis_tlast);
          fail_count++;
        end
        if (m_axis_tdata[7] !== 1'b0) begin
          $error("tdata[7] mismatch: expected 0 actual %0b", m_axis_tdata[7]);
          fail_count++;
        end
      end
    end
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Offer one byte; returns at the edge where the transfer took place
  task automatic send_byte(input logic [7:0] b, input logic eom);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= eom;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    encode_byte(b, eom);
  endtask

  task automatic send_random_message(input int len);
    for (int i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)), i == len - 1);
  endtask

  // Stop offering and let every expected character drain out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_line_length(input logic [9:0] len);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    line_len = len;
    cfg_we_i <= 1'b0;
  endtask

  // Padding counts, all-zero and all-one bytes, no wrapping
  task automatic test_padding();
    set_line_length(LineOff);
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'h4d, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6e, 1'b1);
  endtask

  // Line length 1: last byte yields three characters, each after a newline
  task automatic test_worst_wrap();
    set_line_length(LineMin);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b1);
    set_line_length(10'd3);
    send_byte(8'ha5, 1'b1);   // padding lands across the wrap
  endtask

  // Shrink the line below the current column in the middle of a message
  task automatic test_line_change_mid_message();
    set_line_length(LineMax);
    for (int i = 0; i < 9; i++) send_byte(8'(8'h11 * i + 8'h0f), 1'b0);
    set_line_length(10'd5);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'h01, 1'b1);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input logic [9:0] len, input int n_items);
    int sent;
    int msg_len;
    set_line_length(len);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      msg_len = $urandom_range(1, 12);
      send_random_message(msg_len);
      sent += msg_len;
    end
  endtask

  // Receiver holds off for a long stretch while bytes keep coming
  task automatic test_backpressure();
    set_line_length(10'd7);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b1;
    send_random_message(10);
    send_random_message(10);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_padding();
    test_worst_wrap();
    test_line_change_mid_message();
    test_random_traffic(0, 0, 10'd4, 32);
    test_random_traffic(61, 0, LineMin, 32);
    test_random_traffic(0, 61, LineOff, 32);
    test_random_traffic(19, 19, 10'($urandom_range(2, 20)), 32);
    test_backpressure();

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("base64_stream_encoder_unit_test: PASS");
    end else begin
      $display("base64_stream_encoder_unit_test: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
design/b64enc_pkg.sv
design/b64enc_front.sv
design/b64enc_fifo.sv
design/b64enc_back.sv
design/base64_stream_encoder_unit.sv
bench/base64_stream_encoder_unit_test.sv
